// ===== rtl/assert_macros.svh =====
// ============================================================================
// assertion macros
// shorthand for clocked assertions with the block's clock and reset
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define SIT_ASSERT_IMPL(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("sorted insert table: assertion failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define SIT_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("sorted insert table: assertion failed");

`endif

// ===== rtl/sit_pkg.sv =====
// ============================================================================
// sit_pkg
// shared constants, codes and types of the sorted insert table
// ============================================================================
package sit_pkg;

    // default sizes
    localparam int DEPTH_DEF     = 16;
    localparam int KEY_WIDTH_DEF = 32;

    // fixed field widths
    localparam int IN_KEY_W = 32;
    localparam int INDEX_W  = 4;
    localparam int POS_W    = 4;
    localparam int CNT_W    = 5;
    localparam int STATUS_W = 2;
    localparam int OPCODE_W = 2;
    localparam int MODE_W   = 2;

    // operation codes
    localparam logic [OPCODE_W-1:0] OP_ADD    = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_FIND   = 2'd2;

    // order modes
    localparam logic [MODE_W-1:0] MODE_APPEND = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ASC    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_DESC   = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE     = 2'd3;

    // control broadcast to every cell
    typedef struct packed {
        logic                sample;
        logic [OPCODE_W-1:0] opcode;
        logic [MODE_W-1:0]   mode;
        logic                commit_add;
        logic                commit_remove;
    } sit_cell_ctrl_t;

endpackage

// ===== rtl/sit_if.sv =====
// ============================================================================
// sit_if
// valid/ready channels for command items and result items
// ============================================================================

// command channel
interface sit_in_if import sit_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [OPCODE_W-1:0] opcode;
    logic [IN_KEY_W-1:0] key;
    logic [INDEX_W-1:0]  index;

    modport source (output valid, output opcode, output key, output index, input ready);
    modport sink   (input valid, input opcode, input key, input index, output ready);
endinterface

// result channel
interface sit_out_if import sit_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [POS_W-1:0]    position;
    logic [CNT_W-1:0]    entry_count;

    modport source (output valid, output status, output position, output entry_count,
                    input ready);
    modport sink   (input valid, input status, input position, input entry_count,
                    output ready);
endinterface

// ===== rtl/sit_cell.sv =====
// ============================================================================
// sit_cell
// one table slot: holds a key and its valid bit, compares against the
// broadcast key and shifts from either neighbor
// ============================================================================
module sit_cell import sit_pkg::*;
#(
    parameter int KEY_WIDTH = KEY_WIDTH_DEF,
    parameter int CELL_ID   = 0
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  sit_cell_ctrl_t       ctrl,
    input  logic [KEY_WIDTH-1:0] bkey,
    input  logic [INDEX_W-1:0]   bindex,
    input  logic [KEY_WIDTH-1:0] left_key,
    input  logic                 left_valid,
    input  logic [KEY_WIDTH-1:0] right_key,
    input  logic                 right_valid,
    input  logic                 below,
    input  logic                 first,
    output logic [KEY_WIDTH-1:0] key_q,
    output logic                 valid_q,
    output logic                 stop_q
);

    logic [KEY_WIDTH-1:0] key_reg;
    logic [KEY_WIDTH-1:0] key_next;
    logic                 valid_reg;
    logic                 valid_next;
    logic                 stop_reg;
    logic                 stop_next;
    logic                 skip;

    // insertion scan passes over this slot
    always_comb
    begin
        case (ctrl.mode)
            MODE_ASC:    skip = valid_reg & (key_reg < bkey);
            MODE_DESC:   skip = valid_reg & (key_reg > bkey);
            MODE_APPEND: skip = valid_reg;
            default:     skip = valid_reg;
        endcase
    end

    // per-slot flag for the operation
    always_comb
    begin
        case (ctrl.opcode)
            OP_ADD:    stop_next = !skip;
            OP_REMOVE: stop_next = (int'(bindex) == CELL_ID);
            OP_FIND:   stop_next = valid_reg && (key_reg == bkey);
            default:   stop_next = 1'b0;
        endcase
    end

    // shift up on insert, down on remove, slots below the spot hold
    always_comb
    begin
        key_next   = key_reg;
        valid_next = valid_reg;
        if (ctrl.commit_add && !below)
        begin
            if (first)
            begin
                key_next   = bkey;
                valid_next = 1'b1;
            end
            else
            begin
                key_next   = left_key;
                valid_next = left_valid;
            end
        end
        else if (ctrl.commit_remove && !below)
        begin
            key_next   = right_key;
            valid_next = right_valid;
        end
    end

    // control bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            stop_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (ctrl.sample)
            begin
                stop_reg <= stop_next;
            end
        end
    end

    // key storage
    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

    assign key_q   = key_reg;
    assign valid_q = valid_reg;
    assign stop_q  = stop_reg;

endmodule

// ===== rtl/sit_locate.sv =====
// ============================================================================
// sit_locate
// finds the lowest flagged slot of the row: one-hot spot, mask of the slots
// below it, hit flag and encoded position
// ============================================================================
module sit_locate import sit_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  logic [DEPTH-1:0]         stop,
    output logic [DEPTH-1:0]         below,
    output logic [DEPTH-1:0]         first,
    output logic                     found,
    output logic [$clog2(DEPTH)-1:0] pos
);

    localparam int IDX_W = $clog2(DEPTH);

    logic [DEPTH-1:0] dec;

    // borrow runs up to the lowest set bit
    assign dec   = stop - DEPTH'(1);
    assign below = dec & ~stop;
    assign first = stop & ~dec;
    assign found = |stop;

    // one-hot to binary
    always_comb
    begin
        pos = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (first[i])
            begin
                pos = pos | IDX_W'(i);
            end
        end
    end

endmodule

// ===== rtl/sorted_insert_table.sv =====
// ============================================================================
// sorted_insert_table
// table of keys kept in insertion, ascending or descending order, built as
// a row of slot cells with add, remove-at-index and find operations
// ============================================================================
//
//  channel  | dir | handshake        | payload
//  ---------+-----+------------------+----------------------------------
//  cmd      | in  | valid / ready    | opcode, key, index
//  rsp      | out | valid / ready    | status, position, entry_count
//  cfg      | in  | cfg_write_en     | cfg_write_data (order mode)
//
//  each item is taken in the idle state, where every cell compares at acceptance;
//  then in the commit state the lowest flagged cell is located and the row shifts
//  cmd.ready is high only between items, so a new item is not taken until the
//  last one has committed; a result waiting in the output register does not
//  block acceptance; the next item's shift waits until that result is taken
//  reset clears the valid bits, the count and the mode; keys are not cleared
//
module sorted_insert_table import sit_pkg::*;
#(
    parameter int DEPTH     = DEPTH_DEF,
    parameter int KEY_WIDTH = KEY_WIDTH_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_write_en,
    input  logic [MODE_W-1:0] cfg_write_data,
    sit_in_if.sink            cmd,
    sit_out_if.source         rsp
);

    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_IW = $clog2(DEPTH + 1);
    localparam int RW     = (CNT_IW > INDEX_W) ? CNT_IW : INDEX_W;

    localparam logic [0:0] S_IDLE   = 1'b0;
    localparam logic [0:0] S_COMMIT = 1'b1;

    logic [0:0]           state_reg;
    logic [0:0]           state_next;
    logic [MODE_W-1:0]    mode_reg;
    logic [CNT_IW-1:0]    count_reg;
    logic [CNT_IW-1:0]    count_next;
    logic [OPCODE_W-1:0]  op_reg;
    logic [KEY_WIDTH-1:0] key_reg;
    logic [INDEX_W-1:0]   idx_reg;

    logic [KEY_WIDTH-1:0] cmd_key_w;
    logic [KEY_WIDTH-1:0] bkey;
    logic                 accept;
    logic                 can_out;
    logic                 commit;
    logic                 do_add;
    logic                 do_rem;
    logic [STATUS_W-1:0]  status_d;
    logic [IDX_W-1:0]     pos_d;
    sit_cell_ctrl_t       ctrl;

    logic [KEY_WIDTH-1:0] cell_key   [DEPTH];
    logic [KEY_WIDTH-1:0] left_key   [DEPTH];
    logic [KEY_WIDTH-1:0] right_key  [DEPTH];
    logic [DEPTH-1:0]     cell_valid;
    logic [DEPTH-1:0]     left_valid;
    logic [DEPTH-1:0]     right_valid;
    logic [DEPTH-1:0]     stop;
    logic [DEPTH-1:0]     below;
    logic [DEPTH-1:0]     first;
    logic                 found;
    logic [IDX_W-1:0]     loc_pos;

    logic                        rsp_valid_reg;
    logic [STATUS_W-1:0]         status_reg;
    logic [POS_W-1:0]            position_reg;
    logic [CNT_W-1:0]            entry_count_reg;
    logic [IDX_W+POS_W-1:0]      pos_wide;
    logic [CNT_IW+CNT_W-1:0]     cnt_wide;

    // key narrowed or widened to the stored width
    if (KEY_WIDTH <= IN_KEY_W)
    begin : g_key_narrow
        assign cmd_key_w = cmd.key[KEY_WIDTH-1:0];
    end
    else
    begin : g_key_wide
        assign cmd_key_w = {{(KEY_WIDTH - IN_KEY_W){1'b0}}, cmd.key};
    end

    // handshake and sequencing
    assign cmd.ready = (state_reg == S_IDLE);
    assign accept    = cmd.valid & cmd.ready;
    assign can_out   = !rsp_valid_reg || rsp.ready;
    assign commit    = (state_reg == S_COMMIT) && can_out;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT:
            begin
                if (can_out)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // result of the operation and the new count
    always_comb
    begin
        status_d   = ST_OK;
        pos_d      = '0;
        count_next = count_reg;
        do_add     = 1'b0;
        do_rem     = 1'b0;
        case (op_reg)
            OP_ADD:
            begin
                if (count_reg == CNT_IW'(DEPTH))
                begin
                    status_d = ST_FULL;
                end
                else
                begin
                    do_add     = 1'b1;
                    count_next = CNT_IW'(count_reg + 1'b1);
                    pos_d      = loc_pos;
                end
            end
            OP_REMOVE:
            begin
                if (RW'(idx_reg) >= RW'(count_reg))
                begin
                    status_d = ST_RANGE;
                end
                else
                begin
                    do_rem     = 1'b1;
                    count_next = CNT_IW'(count_reg - 1'b1);
                end
            end
            OP_FIND:
            begin
                if (found)
                begin
                    pos_d = loc_pos;
                end
                else
                begin
                    status_d = ST_NOT_FOUND;
                end
            end
            default: ;
        endcase
    end

    // fit to the output field widths
    assign pos_wide = (IDX_W + POS_W)'(pos_d);
    assign cnt_wide = (CNT_IW + CNT_W)'(count_next);

    // broadcast to the cells
    assign bkey = (state_reg == S_IDLE) ? cmd_key_w : key_reg;

    always_comb
    begin
        ctrl.sample        = accept;
        ctrl.opcode        = cmd.opcode;
        ctrl.mode          = mode_reg;
        ctrl.commit_add    = commit & do_add;
        ctrl.commit_remove = commit & do_rem;
    end

    // row of cells
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        if (i == 0)
        begin : g_left_end
            assign left_key[i]   = bkey;
            assign left_valid[i] = 1'b0;
        end
        else
        begin : g_left_mid
            assign left_key[i]   = cell_key[i-1];
            assign left_valid[i] = cell_valid[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_right_end
            assign right_key[i]   = cell_key[i];
            assign right_valid[i] = 1'b0;
        end
        else
        begin : g_right_mid
            assign right_key[i]   = cell_key[i+1];
            assign right_valid[i] = cell_valid[i+1];
        end

        sit_cell #(
            .KEY_WIDTH (KEY_WIDTH),
            .CELL_ID   (i)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (ctrl),
            .bkey        (bkey),
            .bindex      (cmd.index),
            .left_key    (left_key[i]),
            .left_valid  (left_valid[i]),
            .right_key   (right_key[i]),
            .right_valid (right_valid[i]),
            .below       (below[i]),
            .first       (first[i]),
            .key_q       (cell_key[i]),
            .valid_q     (cell_valid[i]),
            .stop_q      (stop[i])
        );
    end

    // lowest flagged cell
    sit_locate #(
        .DEPTH (DEPTH)
    ) u_locate (
        .stop  (stop),
        .below (below),
        .first (first),
        .found (found),
        .pos   (loc_pos)
    );

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mode_reg      <= MODE_APPEND;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_write_en)
            begin
                mode_reg <= cfg_write_data;
            end
            if (commit)
            begin
                count_reg     <= count_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // item capture and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= cmd.opcode;
            key_reg <= cmd_key_w;
            idx_reg <= cmd.index;
        end
        if (commit)
        begin
            status_reg      <= status_d;
            position_reg    <= pos_wide[POS_W-1:0];
            entry_count_reg <= cnt_wide[CNT_W-1:0];
        end
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.status      = status_reg;
    assign rsp.position    = position_reg;
    assign rsp.entry_count = entry_count_reg;

endmodule

// ===== rtl/sit_checker.sv =====
// ============================================================================
// sit_checker
// port-level checks of the sorted insert table, bound to the top level
// ============================================================================
`include "assert_macros.svh"

module sit_checker import sit_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input logic                clk,
    input logic                rst_n,
    input logic                cmd_valid,
    input logic                cmd_ready,
    input logic                rsp_valid,
    input logic                rsp_ready,
    input logic [STATUS_W-1:0] rsp_status,
    input logic [POS_W-1:0]    rsp_position,
    input logic [CNT_W-1:0]    rsp_entry_count
);

    // one item at a time: no acceptance right after an acceptance
    `SIT_ASSERT_NEXT(a_one_in_flight, cmd_valid && cmd_ready, !cmd_ready)

    // a stalled result holds
    `SIT_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_position) && $stable(rsp_entry_count))

    // failed operations report position zero
    `SIT_ASSERT_IMPL(a_fail_pos, rsp_valid && (rsp_status == ST_FULL || rsp_status == ST_NOT_FOUND || rsp_status == ST_RANGE), rsp_position == '0)

    // full only when the table holds every slot
    `SIT_ASSERT_IMPL(a_full_count, rsp_valid && rsp_status == ST_FULL, rsp_entry_count == CNT_W'(DEPTH))

endmodule

bind sorted_insert_table sit_checker #(
    .DEPTH (DEPTH)
) u_sit_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd_valid       (cmd.valid),
    .cmd_ready       (cmd.ready),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_status      (rsp.status),
    .rsp_position    (rsp.position),
    .rsp_entry_count (rsp.entry_count)
);
